### src/gna_pkg.sv
// ---------------------------------------------------------------------------
// gna_pkg: shared types and constants for the gauge needle angle alarm
// Coordinate widths, CORDIC setup, arctangent table and pipeline records.
// ---------------------------------------------------------------------------
package gna_pkg;

   localparam int COORD_W       = 16;
   localparam int VEC_W         = 32;
   localparam int ANGLE_W       = 32;
   localparam int UNIT_W        = 15;
   localparam int LANES         = 3;
   localparam int LANE_A        = 0;
   localparam int LANE_B        = 1;
   localparam int LANE_C        = 2;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int CORDIC_RUN    = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

   // prep stage + rotation stages + difference stage + scaling stage
   localparam int LATENCY       = CORDIC_RUN + 3;

   localparam logic [ANGLE_W-1:0] HALF_TURN      = 32'h8000_0000;
   localparam logic [UNIT_W-1:0]  UNITS_PER_TURN = 15'd23040;
   localparam logic [UNIT_W-1:0]  UNITS_MAX      = 15'd23039;

   // round(atan(2^-i) / 360 deg * 2^32)
   localparam logic [ANGLE_W-1:0] ATAN_TAB [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic [ANGLE_W-1:0]      z;
      logic                    zero;
   } vec_type;

   typedef struct packed {
      logic valid;
      logic complete;
      logic b_left;
   } tag_type;

endpackage

### src/gna_prep.sv
// ---------------------------------------------------------------------------
// gna_prep: vector setup
// Forms the three centre-relative vectors (y up, scaled by 4096), folds the
// left half plane onto the right one and registers them with the item tag.
// ---------------------------------------------------------------------------
module gna_prep (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   input  logic [gna_pkg::COORD_W-1:0]           a_x,
   input  logic [gna_pkg::COORD_W-1:0]           a_y,
   input  logic [gna_pkg::COORD_W-1:0]           b_x,
   input  logic [gna_pkg::COORD_W-1:0]           b_y,
   input  logic [gna_pkg::COORD_W-1:0]           c_x,
   input  logic [gna_pkg::COORD_W-1:0]           c_y,
   input  logic [gna_pkg::COORD_W-1:0]           o_x,
   input  logic [gna_pkg::COORD_W-1:0]           o_y,
   input  logic                                  a_present,
   input  logic                                  b_present,
   input  logic                                  c_present,
   input  logic                                  o_present,
   output gna_pkg::vec_type [gna_pkg::LANES-1:0] vec_o,
   output gna_pkg::tag_type                      tag_o
);

   localparam int DiffW  = gna_pkg::COORD_W + 1;
   localparam int ScaleW = 12;
   localparam int PadW   = gna_pkg::VEC_W - DiffW - ScaleW;

   gna_pkg::vec_type [gna_pkg::LANES-1:0] vec_in, vec_ff;
   gna_pkg::tag_type                      tag_in, tag_ff;

   function automatic gna_pkg::vec_type make_vec(
      input logic [gna_pkg::COORD_W-1:0] px,
      input logic [gna_pkg::COORD_W-1:0] py,
      input logic [gna_pkg::COORD_W-1:0] ox,
      input logic [gna_pkg::COORD_W-1:0] oy
   );
      logic signed [DiffW-1:0]          dx;
      logic signed [DiffW-1:0]          dy;
      logic signed [gna_pkg::VEC_W-1:0] xw;
      logic signed [gna_pkg::VEC_W-1:0] yw;
      gna_pkg::vec_type                 v;
      dx = signed'({1'b0, px}) - signed'({1'b0, ox});
      dy = signed'({1'b0, oy}) - signed'({1'b0, py});
      xw = {{PadW{dx[DiffW-1]}}, dx, {ScaleW{1'b0}}};
      yw = {{PadW{dy[DiffW-1]}}, dy, {ScaleW{1'b0}}};
      v.zero = (dx == '0) && (dy == '0);
      if (dx[DiffW-1]) begin
         // left half plane: rotate by a half turn first
         v.x = -xw;
         v.y = -yw;
         v.z = gna_pkg::HALF_TURN;
      end else begin
         v.x = xw;
         v.y = yw;
         v.z = '0;
      end
      return v;
   endfunction

   always_comb begin
      vec_in[gna_pkg::LANE_A] = make_vec(a_x, a_y, o_x, o_y);
      vec_in[gna_pkg::LANE_B] = make_vec(b_x, b_y, o_x, o_y);
      vec_in[gna_pkg::LANE_C] = make_vec(c_x, c_y, o_x, o_y);
      tag_in.valid    = in_valid;
      tag_in.complete = a_present & b_present & c_present & o_present;
      tag_in.b_left   = (b_x < a_x);
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_in;
      end
   end

   assign vec_o = vec_ff;
   assign tag_o = tag_ff;

endmodule

### src/gna_cordic.sv
// ---------------------------------------------------------------------------
// gna_cordic: unrolled vectoring CORDIC
// One register stage per micro-rotation, three vectors side by side; the
// item tag travels alongside in its own register chain.
// ---------------------------------------------------------------------------
module gna_cordic (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gna_pkg::vec_type [gna_pkg::LANES-1:0] vec_i,
   input  gna_pkg::tag_type                      tag_i,
   output gna_pkg::vec_type [gna_pkg::LANES-1:0] vec_o,
   output gna_pkg::tag_type                      tag_o
);

   localparam int Stg  = gna_pkg::CORDIC_RUN;
   localparam int VecW = gna_pkg::VEC_W;

   gna_pkg::vec_type [gna_pkg::LANES-1:0] vec_ff [Stg];
   gna_pkg::tag_type                      tag_ff [Stg];

   for (genvar s = 0; s < Stg; s++) begin : g_stage
      gna_pkg::vec_type [gna_pkg::LANES-1:0] src;
      gna_pkg::vec_type [gna_pkg::LANES-1:0] vec_in;
      gna_pkg::tag_type                      tag_src;

      if (s == 0) begin : g_first
         assign src     = vec_i;
         assign tag_src = tag_i;
      end else begin : g_next
         assign src     = vec_ff[s-1];
         assign tag_src = tag_ff[s-1];
      end

      always_comb begin
         logic signed [VecW-1:0] xs;
         logic signed [VecW-1:0] ys;
         for (int l = 0; l < gna_pkg::LANES; l++) begin
            xs        = src[l].x >>> s;
            ys        = src[l].y >>> s;
            vec_in[l] = src[l];
            // steer y toward zero
            if (!src[l].y[VecW-1]) begin
               vec_in[l].x = src[l].x + ys;
               vec_in[l].y = src[l].y - xs;
               vec_in[l].z = src[l].z + gna_pkg::ATAN_TAB[s];
            end else begin
               vec_in[l].x = src[l].x - ys;
               vec_in[l].y = src[l].y + xs;
               vec_in[l].z = src[l].z - gna_pkg::ATAN_TAB[s];
            end
         end
      end

      always_ff @(posedge clock) begin
         vec_ff[s] <= vec_in;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            tag_ff[s] <= '0;
         end else begin
            tag_ff[s] <= tag_src;
         end
      end
   end

   assign vec_o = vec_ff[Stg-1];
   assign tag_o = tag_ff[Stg-1];

endmodule

### src/gna_post.sv
// ---------------------------------------------------------------------------
// gna_post: angle differences, unit scaling and alarm
// Stage one forms the clockwise differences; stage two scales them to
// 1/64 degree, compares, and drives the result word registers.
// ---------------------------------------------------------------------------
module gna_post (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gna_pkg::vec_type [gna_pkg::LANES-1:0] vec_i,
   input  gna_pkg::tag_type                      tag_i,
   output logic                                  out_valid,
   output logic [gna_pkg::UNIT_W-1:0]            angle_a_to_b,
   output logic [gna_pkg::UNIT_W-1:0]            angle_a_to_c,
   output logic                                  over_limit,
   output logic                                  points_complete
);

   localparam int AngW  = gna_pkg::ANGLE_W;
   localparam int UnitW = gna_pkg::UNIT_W;
   localparam int ProdW = AngW + UnitW;

   logic [AngW-1:0]   ang_a, ang_b, ang_c;
   logic [AngW-1:0]   aob_in, aoc_in, boc_in;
   logic [AngW-1:0]   aob_ff, aoc_ff, boc_ff;
   gna_pkg::tag_type  tag_ff;
   logic [ProdW-1:0]  prod_ab, prod_ac;
   logic              over;
   logic              valid_ff;
   logic [UnitW-1:0]  ab_in, ac_in, ab_ff, ac_ff;
   logic              over_in, over_ff, complete_ff;

   // a point on the centre has angle zero
   assign ang_a = vec_i[gna_pkg::LANE_A].zero ? '0 : vec_i[gna_pkg::LANE_A].z;
   assign ang_b = vec_i[gna_pkg::LANE_B].zero ? '0 : vec_i[gna_pkg::LANE_B].z;
   assign ang_c = vec_i[gna_pkg::LANE_C].zero ? '0 : vec_i[gna_pkg::LANE_C].z;

   assign aob_in = ang_a - ang_b;
   assign aoc_in = ang_a - ang_c;
   assign boc_in = tag_i.b_left ? (ang_b - ang_c) : (ang_c - ang_b);

   always_ff @(posedge clock) begin
      aob_ff <= aob_in;
      aoc_ff <= aoc_in;
      boc_ff <= boc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else begin
         tag_ff <= tag_i;
      end
   end

   assign prod_ab = aob_ff * gna_pkg::UNITS_PER_TURN;
   assign prod_ac = aoc_ff * gna_pkg::UNITS_PER_TURN;
   assign over    = (aoc_ff >= aob_ff) || (boc_ff >= aob_ff);

   // drop everything but the flag when a point is missing
   assign ab_in   = tag_ff.complete ? prod_ab[ProdW-1:AngW] : '0;
   assign ac_in   = tag_ff.complete ? prod_ac[ProdW-1:AngW] : '0;
   assign over_in = tag_ff.complete & over;

   always_ff @(posedge clock) begin
      ab_ff       <= ab_in;
      ac_ff       <= ac_in;
      over_ff     <= over_in;
      complete_ff <= tag_ff.complete;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= tag_ff.valid;
      end
   end

   assign out_valid       = valid_ff;
   assign angle_a_to_b    = ab_ff;
   assign angle_a_to_c    = ac_ff;
   assign over_limit      = over_ff;
   assign points_complete = complete_ff;

endmodule

### src/gauge_needle_angle_alarm_top.sv
// ---------------------------------------------------------------------------
// gauge_needle_angle_alarm_top: gauge needle angle alarm
// Clockwise angles AOB and AOC about the dial centre, plus an over-limit
// alarm, from four keypoints per word.
// ---------------------------------------------------------------------------
//   channel   direction   handshake            payload
//   request   in          start, busy          req_* coordinates, presence
//   response  out         rsp_valid (strobe)   rsp_* angles, alarm, complete
//
// A word is taken whenever start is high; busy is always low, so one word
// per cycle is sustained. The pipeline has one setup stage, one stage per
// CORDIC micro-rotation, one difference stage and one scaling stage. Each
// response is shown for one cycle only; the receiver cannot stall, so
// nothing in the pipeline waits.
// Synchronous reset clears the valid chain; data registers are not reset.
// ---------------------------------------------------------------------------
module gauge_needle_angle_alarm_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gna_pkg::COORD_W-1:0]       req_a_x,
   input  logic [gna_pkg::COORD_W-1:0]       req_a_y,
   input  logic [gna_pkg::COORD_W-1:0]       req_b_x,
   input  logic [gna_pkg::COORD_W-1:0]       req_b_y,
   input  logic [gna_pkg::COORD_W-1:0]       req_c_x,
   input  logic [gna_pkg::COORD_W-1:0]       req_c_y,
   input  logic [gna_pkg::COORD_W-1:0]       req_o_x,
   input  logic [gna_pkg::COORD_W-1:0]       req_o_y,
   input  logic                              req_a_present,
   input  logic                              req_b_present,
   input  logic                              req_c_present,
   input  logic                              req_o_present,
   output logic                              rsp_valid,
   output logic [gna_pkg::UNIT_W-1:0]        rsp_angle_a_to_b,
   output logic [gna_pkg::UNIT_W-1:0]        rsp_angle_a_to_c,
   output logic                              rsp_over_limit,
   output logic                              rsp_points_complete
);

   gna_pkg::vec_type [gna_pkg::LANES-1:0] prep_vec, cordic_vec;
   gna_pkg::tag_type                      prep_tag, cordic_tag;
   logic                                  take;

   assign busy = 1'b0;
   assign take = start && !busy;

   gna_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (take),
      .a_x       (req_a_x),
      .a_y       (req_a_y),
      .b_x       (req_b_x),
      .b_y       (req_b_y),
      .c_x       (req_c_x),
      .c_y       (req_c_y),
      .o_x       (req_o_x),
      .o_y       (req_o_y),
      .a_present (req_a_present),
      .b_present (req_b_present),
      .c_present (req_c_present),
      .o_present (req_o_present),
      .vec_o     (prep_vec),
      .tag_o     (prep_tag)
   );

   gna_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .vec_i (prep_vec),
      .tag_i (prep_tag),
      .vec_o (cordic_vec),
      .tag_o (cordic_tag)
   );

   gna_post u_post (
      .clock           (clock),
      .reset           (reset),
      .vec_i           (cordic_vec),
      .tag_i           (cordic_tag),
      .out_valid       (rsp_valid),
      .angle_a_to_b    (rsp_angle_a_to_b),
      .angle_a_to_c    (rsp_angle_a_to_c),
      .over_limit      (rsp_over_limit),
      .points_complete (rsp_points_complete)
   );

   // every response traces back to a word taken while start was high
   a_rsp_has_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, gna_pkg::LATENCY))
      else $error("response without a matching request word");

   a_incomplete_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_points_complete) |->
         (rsp_angle_a_to_b == '0 && rsp_angle_a_to_c == '0 && !rsp_over_limit))
      else $error("incomplete point set must give a zero response");

   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_angle_a_to_b <= gna_pkg::UNITS_MAX &&
                     rsp_angle_a_to_c <= gna_pkg::UNITS_MAX))
      else $error("angle beyond one full turn");

   a_alarm_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_points_complete && rsp_angle_a_to_c > rsp_angle_a_to_b)
         |-> rsp_over_limit)
      else $error("needle past scale end without alarm");

endmodule
